[rtl/afda_pkg.sv]
package afda_pkg;

  localparam int unsigned MAX_AVERAGE = 256;
  localparam int unsigned CNT_W = 9;
  localparam int unsigned SMP_W = 18;
  localparam int unsigned SUM_W = 27;
  localparam int unsigned DIV_W = SUM_W - 1;
  localparam int unsigned STEP_W = $clog2(DIV_W);

  typedef enum logic [1:0] {
    RES_12 = 2'd0,
    RES_14 = 2'd1,
    RES_16 = 2'd2,
    RES_18 = 2'd3
  } res_e;

  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_NOT_READY = 2'd1,
    STAT_UNDERFLOW = 2'd2,
    STAT_OVERFLOW  = 2'd3
  } stat_e;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_DIV  = 3'b010,
    S_DONE = 3'b100
  } state_e;

  typedef struct packed {
    logic signed [SMP_W-1:0] sample;
    logic [1:0]              channel_sel;
    logic [1:0]              resolution_sel;
    logic [1:0]              gain_sel;
    logic                    continuous;
    logic                    ready_res;
    logic [1:0]              status;
    logic                    average_valid;
  } result_t;

  function automatic logic signed [SMP_W-1:0] lo_lim(input res_e res);
    logic signed [SMP_W-1:0] lim;
    unique case (res)
      RES_12:  lim = -18'sd2048;
      RES_14:  lim = -18'sd8192;
      RES_16:  lim = -18'sd32768;
      RES_18:  lim = -18'sd131072;
      default: lim = -18'sd131072;
    endcase
    return lim;
  endfunction

  function automatic logic signed [SMP_W-1:0] hi_lim(input res_e res);
    logic signed [SMP_W-1:0] lim;
    unique case (res)
      RES_12:  lim = 18'sd2047;
      RES_14:  lim = 18'sd8191;
      RES_16:  lim = 18'sd32767;
      RES_18:  lim = 18'sd131071;
      default: lim = 18'sd131071;
    endcase
    return lim;
  endfunction

endpackage

[rtl/afda_in_if.sv]
interface afda_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte0;
  logic [7:0] byte1;
  logic [7:0] byte2;
  logic [7:0] byte3;

  modport source (output valid, output byte0, output byte1, output byte2, output byte3,
                  input ready);
  modport sink (input valid, input byte0, input byte1, input byte2, input byte3,
                output ready);
endinterface

[rtl/afda_out_if.sv]
interface afda_out_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [afda_pkg::SMP_W-1:0]    sample;
  logic [1:0]                           channel_sel;
  logic [1:0]                           resolution_sel;
  logic [1:0]                           gain_sel;
  logic                                 continuous;
  logic                                 ready_res;
  logic [1:0]                           status;
  logic                                 average_valid;
  logic signed [afda_pkg::SMP_W-1:0]    average;

  modport source (output valid, output sample, output channel_sel, output resolution_sel,
                  output gain_sel, output continuous, output ready_res, output status,
                  output average_valid, output average, input ready);
  modport sink (input valid, input sample, input channel_sel, input resolution_sel,
                input gain_sel, input continuous, input ready_res, input status,
                input average_valid, input average, output ready);
endinterface

[rtl/adc_frame_decode_average.sv]
// A frame is held in a pending register until the output register is free; a frame that
// completes an average first passes through the 26-step restoring divider.
// No new frame is accepted until the previous one has moved into the output register.
// A finished item waits in the output register while the next frame is taken.
// Reset is asynchronous and active low; it clears the sum and count and sets the
// average count to 1.
module adc_frame_decode_average (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [afda_pkg::CNT_W-1:0] cfg_wdata_i,
  afda_in_if.sink                    in_i,
  afda_out_if.source                 out_o
);

  afda_pkg::state_e state_q, state_d;
  logic [afda_pkg::CNT_W-1:0]  avg_count_q, avg_count_d;
  logic signed [afda_pkg::SUM_W-1:0] sum_q, sum_d;
  logic [afda_pkg::CNT_W-1:0]  taken_q, taken_d;
  logic [afda_pkg::STEP_W-1:0] step_q, step_d;
  logic                        out_valid_q, out_valid_d;

  afda_pkg::result_t           pend_q, pend_d;
  afda_pkg::result_t           out_q, out_d;
  logic signed [afda_pkg::SMP_W-1:0] out_avg_q, out_avg_d;
  logic [afda_pkg::DIV_W-1:0]  quot_q, quot_d;
  logic [afda_pkg::CNT_W-1:0]  rem_q, rem_d;
  logic [afda_pkg::CNT_W-1:0]  div_q, div_d;
  logic                        neg_q, neg_d;

  logic [7:0]                  st;
  afda_pkg::res_e              res;
  logic signed [afda_pkg::SMP_W-1:0] sample;
  logic [1:0]                  code;
  logic [afda_pkg::CNT_W-1:0]  target;
  logic [afda_pkg::CNT_W-1:0]  taken_new;
  logic signed [afda_pkg::SUM_W-1:0] sum_new;
  logic [afda_pkg::SUM_W-1:0]  sum_mag;
  logic [afda_pkg::CNT_W:0]    trial;
  logic [afda_pkg::CNT_W:0]    diff;
  logic                        geq;
  logic                        accept;
  logic                        out_free;

  assign accept   = in_i.valid && in_i.ready;
  assign out_free = !out_valid_q || out_o.ready;
  assign in_i.ready = (state_q == afda_pkg::S_IDLE);

  always_comb begin
    st  = (in_i.byte3[3:2] == 2'b11) ? in_i.byte3 : in_i.byte2;
    res = afda_pkg::res_e'(st[3:2]);
    unique case (res)
      afda_pkg::RES_12: sample = {{6{in_i.byte0[3]}}, in_i.byte0[3:0], in_i.byte1};
      afda_pkg::RES_14: sample = {{4{in_i.byte0[5]}}, in_i.byte0[5:0], in_i.byte1};
      afda_pkg::RES_16: sample = {{2{in_i.byte0[7]}}, in_i.byte0, in_i.byte1};
      afda_pkg::RES_18: sample = {in_i.byte0[1:0], in_i.byte1, in_i.byte2};
      default:          sample = {in_i.byte0[1:0], in_i.byte1, in_i.byte2};
    endcase
    priority if (st[7]) begin
      code = afda_pkg::STAT_NOT_READY;
    end else if (sample <= afda_pkg::lo_lim(res)) begin
      code = afda_pkg::STAT_UNDERFLOW;
    end else if (sample >= afda_pkg::hi_lim(res)) begin
      code = afda_pkg::STAT_OVERFLOW;
    end else begin
      code = afda_pkg::STAT_OK;
    end

    priority if (avg_count_q == '0) begin
      target = afda_pkg::CNT_W'(1);
    end else if (avg_count_q > afda_pkg::CNT_W'(afda_pkg::MAX_AVERAGE)) begin
      target = afda_pkg::CNT_W'(afda_pkg::MAX_AVERAGE);
    end else begin
      target = avg_count_q;
    end
    taken_new = taken_q + afda_pkg::CNT_W'(1);
    sum_new   = sum_q + {{(afda_pkg::SUM_W - afda_pkg::SMP_W){sample[afda_pkg::SMP_W-1]}},
                         sample};
    sum_mag   = sum_new[afda_pkg::SUM_W-1] ? (~sum_new + afda_pkg::SUM_W'(1)) : sum_new;

    trial = {rem_q, quot_q[afda_pkg::DIV_W-1]};
    diff  = trial - {1'b0, div_q};
    geq   = (trial >= {1'b0, div_q});
  end

  always_comb begin
    state_d     = state_q;
    avg_count_d = cfg_we_i ? cfg_wdata_i : avg_count_q;
    sum_d       = sum_q;
    taken_d     = taken_q;
    step_d      = step_q;
    out_valid_d = out_valid_q;
    pend_d      = pend_q;
    out_d       = out_q;
    out_avg_d   = out_avg_q;
    quot_d      = quot_q;
    rem_d       = rem_q;
    div_d       = div_q;
    neg_d       = neg_q;

    if (out_valid_q && out_o.ready) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      afda_pkg::S_IDLE: begin
        if (accept) begin
          pend_d.sample         = sample;
          pend_d.channel_sel    = st[6:5];
          pend_d.resolution_sel = st[3:2];
          pend_d.gain_sel       = st[1:0];
          pend_d.continuous     = st[4];
          pend_d.ready_res      = !st[7];
          pend_d.status         = code;
          pend_d.average_valid  = 1'b0;
          quot_d  = '0;
          neg_d   = 1'b0;
          rem_d   = '0;
          state_d = afda_pkg::S_DONE;
          if (code != afda_pkg::STAT_OK) begin
            sum_d   = '0;
            taken_d = '0;
          end else if (taken_new >= target) begin
            pend_d.average_valid = 1'b1;
            sum_d   = '0;
            taken_d = '0;
            quot_d  = sum_mag[afda_pkg::DIV_W-1:0];
            neg_d   = sum_new[afda_pkg::SUM_W-1];
            div_d   = taken_new;
            step_d  = afda_pkg::STEP_W'(afda_pkg::DIV_W - 1);
            state_d = afda_pkg::S_DIV;
          end else begin
            sum_d   = sum_new;
            taken_d = taken_new;
          end
        end
      end
      afda_pkg::S_DIV: begin
        rem_d  = geq ? diff[afda_pkg::CNT_W-1:0] : trial[afda_pkg::CNT_W-1:0];
        quot_d = {quot_q[afda_pkg::DIV_W-2:0], geq};
        step_d = step_q - afda_pkg::STEP_W'(1);
        if (step_q == '0) begin
          state_d = afda_pkg::S_DONE;
        end
      end
      afda_pkg::S_DONE: begin
        if (out_free) begin
          out_d       = pend_q;
          out_avg_d   = neg_q ? (~quot_q[afda_pkg::SMP_W-1:0] + afda_pkg::SMP_W'(1))
                              : quot_q[afda_pkg::SMP_W-1:0];
          out_valid_d = 1'b1;
          state_d     = afda_pkg::S_IDLE;
        end
      end
      default: state_d = afda_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= afda_pkg::S_IDLE;
      avg_count_q <= afda_pkg::CNT_W'(1);
      sum_q       <= '0;
      taken_q     <= '0;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      avg_count_q <= avg_count_d;
      sum_q       <= sum_d;
      taken_q     <= taken_d;
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_q    <= pend_d;
    out_q     <= out_d;
    out_avg_q <= out_avg_d;
    quot_q    <= quot_d;
    rem_q     <= rem_d;
    div_q     <= div_d;
    neg_q     <= neg_d;
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.sample         = out_q.sample;
  assign out_o.channel_sel    = out_q.channel_sel;
  assign out_o.resolution_sel = out_q.resolution_sel;
  assign out_o.gain_sel       = out_q.gain_sel;
  assign out_o.continuous     = out_q.continuous;
  assign out_o.ready_res      = out_q.ready_res;
  assign out_o.status         = out_q.status;
  assign out_o.average_valid  = out_q.average_valid;
  assign out_o.average        = out_avg_q;

endmodule
